FILE: hw/rtl/deq_pkg.sv
// deq_pkg: shared types, sizing constants and slot arithmetic for the
// double-ended queue unit. No dependencies.
package deq_pkg;

  localparam int unsigned DEPTH   = 32;
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W   = CNT_W + 1;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_LIST       = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LIST
  } state_e;

  // (base + off) modulo DEPTH; base < DEPTH and off <= DEPTH.
  function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/deq_ram.sv
// deq_ram: single-clock storage, one write and one read port, registered
// read data that holds while no read is issued. Uses no package.
module deq_ram #(
  parameter int unsigned DATA_W  = 32,
  parameter int unsigned DEPTH_P = 32,
  parameter int unsigned ADDR_W  = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH_P];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: hw/rtl/double_ended_queue_unit.sv
// double_ended_queue_unit: bounded deque of signed 32-bit values in a circular RAM.
// Depends on deq_pkg and deq_ram.
// Push and refused requests give their result in the cycle after acceptance; a pop
// result passes the RAM read register, then the output register. Pops and lists use the
// single RAM read port and hold off new requests until done; unused codes give no result.
// Reset: asynchronous, active low; clears pointers, count, FSM and output valid.
module double_ended_queue_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [deq_pkg::MODE_W-1:0]          mode_i,
  input  logic signed [deq_pkg::DATA_W-1:0]   push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [deq_pkg::DATA_W-1:0]   out_value_o,
  output logic [deq_pkg::STAT_W-1:0]          status_o,
  output logic                                last_o
);
  import deq_pkg::*;

  // Control state
  state_e           state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;   // slot of the front value
  logic [CNT_W-1:0] count_q, count_d;   // values held
  logic [IDX_W-1:0] slot_q, slot_d;     // next slot to read during a list
  logic [CNT_W-1:0] rem_q, rem_d;       // list results still to deliver

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;
  status_e           status_q, status_d;
  logic              last_q, last_d;

  // RAM port
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic  out_free, accept, is_full, is_empty;
  mode_e mode;

  assign mode     = mode_e'(mode_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  deq_ram #(
    .DATA_W (DATA_W),
    .DEPTH_P(DEPTH),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(push_value_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Next state. A transaction is only taken in S_IDLE, and the pointers are
  // updated at acceptance, so a RAM write and a later read of the same entry
  // never fall in one cycle: the FSM itself is the interlock.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((mode == MODE_POP_FRONT || mode == MODE_POP_BACK) && !is_empty) begin
            state_d = S_POP;
          end else if (mode == MODE_LIST && !is_empty) begin
            state_d = S_LIST;
          end
        end
      end
      S_POP:  state_d = S_IDLE;
      S_LIST: begin
        if (out_free && rem_q == CNT_W'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, RAM control and output register loading
  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    slot_d      = slot_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    status_d    = status_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = front_q;
    ram_raddr   = front_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_value_d = '0;
          last_d      = 1'b1;
          status_d    = STAT_OK;
          unique case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              out_valid_d = 1'b1;
              if (is_full) begin
                status_d = STAT_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
                if (mode == MODE_PUSH_FRONT) begin
                  ram_waddr = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
                  front_d   = ram_waddr;
                end else begin
                  ram_waddr = wrap_add(front_q, count_q);
                end
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              if (is_empty) begin
                out_valid_d = 1'b1;
                status_d    = STAT_EMPTY;
              end else begin
                ram_re  = 1'b1;
                count_d = count_q - CNT_W'(1);
                if (mode == MODE_POP_FRONT) begin
                  ram_raddr = front_q;
                  front_d   = wrap_add(front_q, CNT_W'(1));
                end else begin
                  ram_raddr = wrap_add(front_q, count_q - CNT_W'(1));
                end
              end
            end
            MODE_LIST: begin
              if (is_empty) begin
                out_valid_d = 1'b1;
                status_d    = STAT_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = front_q;
                slot_d    = wrap_add(front_q, CNT_W'(1));
                rem_d     = count_q;
              end
            end
            default: begin
              // unused code: dropped, no result
            end
          endcase
        end
      end
      S_POP: begin
        // output register was freed at acceptance
        out_valid_d = 1'b1;
        out_value_d = ram_rdata;
        status_d    = STAT_OK;
        last_d      = 1'b1;
      end
      S_LIST: begin
        // RAM data holds while the output is stalled
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = ram_rdata;
          status_d    = STAT_OK;
          last_d      = (rem_q == CNT_W'(1));
          if (rem_q != CNT_W'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = slot_q;
            slot_d    = wrap_add(slot_q, CNT_W'(1));
            rem_d     = rem_q - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      slot_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      slot_q      <= slot_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    status_q    <= status_d;
    last_q      <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("held count exceeds capacity");

  a_count_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != count_d) |-> accept)
    else $error("held count changed without an accepted transaction");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |=> (out_valid_o && last_o))
    else $error("pop read did not reach the output register");

  a_not_last_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (state_q == S_LIST))
    else $error("non-final result outside a list transaction");

  a_list_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |-> (rem_q != '0 && rem_q <= count_q))
    else $error("list remaining count out of range");
`endif

endmodule

FILE: bench/double_ended_queue_unit_tb.sv
`timescale 1ns / 1ps
// double_ended_queue_unit_tb: self-checking bench for the double-ended queue unit.
// Depends on deq_pkg and double_ended_queue_unit (with its RAM); reads no files.
module double_ended_queue_unit_tb;
  import deq_pkg::*;

  // Codes outside the operation set; the unit must swallow them silently.
  localparam logic [MODE_W-1:0] MODE_RSVD_A = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD_B = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD_C = 3'd7;

  localparam int unsigned RANDOM_REQS = 26;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned DIR_ROWS = 25;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_e                  status;
    logic                     last;
  } deq_result_t;

  // One row of the directed table. A typed row carries its own expected result,
  // used for every repetition; the rest are checked against the deque shadow.
  typedef struct packed {
    logic [MODE_W-1:0] code;
    logic [DATA_W-1:0] val;
    logic [5:0]        reps;
    logic              typed;
    logic [DATA_W-1:0] typed_val;
    status_e           typed_stat;
  } dir_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [MODE_W-1:0]        mode_i;
  logic signed [DATA_W-1:0] push_value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] out_value_o;
  logic [STAT_W-1:0]        status_o;
  logic                     last_o;

  // Shadow copy of the deque contents.
  logic signed [DATA_W-1:0] dq_slots [DEPTH];
  int unsigned              dq_head;
  int unsigned              dq_count;

  deq_result_t want_q [$];   // results still owed by the unit, oldest first
  deq_result_t fresh_q [$];  // results caused by the latest transaction
  int unsigned err_cnt;
  bit          tx_quiet;
  bit          rx_quiet;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{MODE_POP_FRONT,  32'h0000_0000, 6'd1,  1'b1, 32'h0000_0000, STAT_EMPTY},
    '{MODE_POP_BACK,   32'h0000_0000, 6'd1,  1'b1, 32'h0000_0000, STAT_EMPTY},
    '{MODE_LIST,       32'h0000_0000, 6'd1,  1'b1, 32'h0000_0000, STAT_EMPTY},
    '{MODE_PUSH_FRONT, 32'h8000_0000, 6'd1,  1'b1, 32'h0000_0000, STAT_OK},
    '{MODE_PUSH_BACK,  32'h7fff_ffff, 6'd1,  1'b1, 32'h0000_0000, STAT_OK},
    '{MODE_LIST,       32'h0000_0000, 6'd1,  1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_POP_BACK,   32'hdead_beef, 6'd1,  1'b1, 32'h7fff_ffff, STAT_OK},
    '{MODE_POP_FRONT,  32'h0000_0000, 6'd1,  1'b1, 32'h8000_0000, STAT_OK},
    '{MODE_PUSH_BACK,  32'hffff_ffff, 6'd1,  1'b1, 32'h0000_0000, STAT_OK},
    '{MODE_PUSH_FRONT, 32'h0000_0000, 6'd1,  1'b1, 32'h0000_0000, STAT_OK},
    '{MODE_PUSH_FRONT, 32'h5555_5555, 6'd1,  1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_PUSH_BACK,  32'haaaa_aaaa, 6'd1,  1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_RSVD_A,     32'h0000_1234, 6'd1,  1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_RSVD_B,     32'h8000_0001, 6'd1,  1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_RSVD_C,     32'hffff_ffff, 6'd1,  1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_LIST,       32'h0000_0000, 6'd1,  1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_POP_BACK,   32'h0000_0000, 6'd1,  1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_POP_FRONT,  32'h0000_0000, 6'd1,  1'b0, 32'h0000_0000, STAT_OK},
    // two values held here: fill to the brim, then knock on both ends
    '{MODE_PUSH_BACK,  32'h0123_4567, 6'd30, 1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_PUSH_FRONT, 32'h1111_1111, 6'd1,  1'b1, 32'h0000_0000, STAT_FULL},
    '{MODE_PUSH_BACK,  32'hffff_ffff, 6'd1,  1'b1, 32'h0000_0000, STAT_FULL},
    '{MODE_LIST,       32'h0000_0000, 6'd1,  1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_POP_FRONT,  32'h0000_0000, 6'd16, 1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_POP_BACK,   32'h0000_0000, 6'd16, 1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_POP_BACK,   32'h0000_0000, 6'd1,  1'b1, 32'h0000_0000, STAT_EMPTY}
  };

  double_ended_queue_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_value_o  (out_value_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void note_result(logic signed [DATA_W-1:0] v, status_e s, logic l);
    fresh_q.push_back('{value: v, status: s, last: l});
  endfunction

  // Deque shadow: applies one accepted request and lists the results it owes.
  function automatic void apply_request(logic [MODE_W-1:0] code,
                                        logic signed [DATA_W-1:0] val);
    int unsigned slot;
    fresh_q.delete();
    case (code)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (dq_count == DEPTH) begin
          note_result('0, STAT_FULL, 1'b1);
        end else begin
          if (code == MODE_PUSH_FRONT) begin
            dq_head = (dq_head + DEPTH - 1) % DEPTH;
            slot = dq_head;
          end else begin
            slot = (dq_head + dq_count) % DEPTH;
          end
          dq_slots[slot] = val;
          dq_count++;
          note_result('0, STAT_OK, 1'b1);
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (dq_count == 0) begin
          note_result('0, STAT_EMPTY, 1'b1);
        end else if (code == MODE_POP_FRONT) begin
          note_result(dq_slots[dq_head], STAT_OK, 1'b1);
          dq_head = (dq_head + 1) % DEPTH;
          dq_count--;
        end else begin
          note_result(dq_slots[(dq_head + dq_count - 1) % DEPTH], STAT_OK, 1'b1);
          dq_count--;
        end
      end
      MODE_LIST: begin
        if (dq_count == 0) begin
          note_result('0, STAT_EMPTY, 1'b1);
        end else begin
          for (int unsigned k = 0; k < dq_count; k++) begin
            note_result(dq_slots[(dq_head + k) % DEPTH], STAT_OK, k + 1 == dq_count);
          end
        end
      end
      default: ;  // unused code: no change, nothing owed
    endcase
  endfunction

  // Present one request, hold it until the handshake, then book what it owes.
  // Valid is only lowered when a gap follows, so it never drops and rises in
  // the same step.
  task automatic send_request(input logic [MODE_W-1:0] code,
                              input logic [DATA_W-1:0] val,
                              input logic typed,
                              input deq_result_t typed_res);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= code;
    push_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    apply_request(code, val);
    if (typed) begin
      want_q.push_back(typed_res);
    end else begin
      foreach (fresh_q[k]) want_q.push_back(fresh_q[k]);
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Request side: reset, directed table, then random grow/shrink phases.
  initial begin
    deq_result_t       typed_res;
    logic [MODE_W-1:0] code;
    int unsigned       counted;
    int unsigned       pick;
    bit                growing;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = '0;
    push_value_i = '0;
    dq_head      = 0;
    dq_count     = 0;
    err_cnt      = 0;
    tx_quiet     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      typed_res = '{value: dir_rows[r].typed_val, status: dir_rows[r].typed_stat, last: 1'b1};
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        send_request(dir_rows[r].code, dir_rows[r].val ^ (k * 32'h9e37_79b9),
                     dir_rows[r].typed, typed_res);
      end
    end

    // Random phase: mostly pushes while growing, mostly pops while shrinking,
    // so the deque grows and shrinks; the budget is below DEPTH, so it never fills
    // from empty here. Unused codes do not count toward the request budget.
    counted = 0;
    growing = 1'b1;
    while (counted < RANDOM_REQS) begin
      if (growing && dq_count == DEPTH && $urandom_range(0, 2) == 0) growing = 1'b0;
      else if (!growing && dq_count == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;
      else if ($urandom_range(0, 39) == 0) growing = !growing;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        code = MODE_W'($urandom_range(int'(MODE_RSVD_A), int'(MODE_RSVD_C)));
      end else if (pick < 12) begin
        code = MODE_LIST;
      end else if ((pick < 80) == growing) begin
        code = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
      end else begin
        code = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
      end
      send_request(code, pick_value(), 1'b0, '0);
      if (code <= MODE_LIST) counted++;
    end
    in_valid_i <= 1'b0;

    while (want_q.size() != 0) @(posedge clk_i);
    // let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: compare every transaction against the oldest owed result,
  // then lower ready for a random hold, except in quiet spells.
  initial begin
    deq_result_t want;
    int unsigned hold;
    out_ready_i = 1'b0;
    hold = 3;
    rx_quiet = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result value %h status %0d last %b", $time,
                   out_value_o, status_o, last_o);
          err_cnt++;
        end else begin
          want = want_q.pop_front();
          if (out_value_o !== want.value) begin
            $display("%0t: out_value expected %h actual %h", $time, want.value, out_value_o);
            err_cnt++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            err_cnt++;
          end
          if (last_o !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, last_o);
            err_cnt++;
          end
        end
        if ($urandom_range(0, 19) == 0) rx_quiet = !rx_quiet;
        hold = rx_quiet ? 0 : $urandom_range(0, 13);
        if (hold != 0) out_ready_i <= 1'b0;
      end else if (!out_ready_i) begin
        if (hold <= 1) out_ready_i <= 1'b1;
        if (hold != 0) hold--;
      end
    end
  end

  // Watchdog: far beyond the slowest legal run (every list at full depth,
  // every result held off for the longest stall).
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
